### sv/assert_macros.svh
// Assertion macros shared by the display shifter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/ssd_pkg.sv
// Shared types, constants and segment tables of the status display shifter.
`default_nettype none

package ssd_pkg;

  // Frame geometry: bits 63 down to 8 of the model frame, sent first to last.
  localparam int FRAME_BITS = 56;
  typedef logic [FRAME_BITS-1:0] frame_t;

  // Digit codes: 0 to 9 are decimal digits, the two others are special.
  typedef logic [3:0] digit_t;
  localparam digit_t DIGIT_DARK = 4'd10;
  localparam digit_t DIGIT_FULL = 4'd11;

  // Request opcodes.
  localparam logic [1:0] OP_SHOW  = 2'd0;
  localparam logic [1:0] OP_LAMP  = 2'd1;
  localparam logic [1:0] OP_BLANK = 2'd2;

  // Warm threshold after reset.
  localparam logic [6:0] WARM_RESET = 7'd80;

  // Segment pattern of the large display.
  function automatic logic [7:0] large_seg(input digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE4;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      4'd10:   s = 8'h00;
      4'd11:   s = 8'hFF;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Segment pattern of the small display, which is wired differently.
  function automatic logic [7:0] small_seg(input digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hBE;
      4'd1:    s = 8'h18;
      4'd2:    s = 8'h76;
      4'd3:    s = 8'h7C;
      4'd4:    s = 8'hD8;
      4'd5:    s = 8'hEC;
      4'd6:    s = 8'hEE;
      4'd7:    s = 8'hB8;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hFC;
      4'd10:   s = 8'h00;
      4'd11:   s = 8'hFF;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/ssd_front.sv
// Front end: accepts requests, tracks the refresh flag and builds frames.
`default_nettype none

`include "assert_macros.svh"

module ssd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      opcode,
  input  wire logic            refresh_request,
  input  wire logic            pid_mode,
  input  wire logic [9:0]      skin_tenths,
  input  wire logic [9:0]      setpoint_value,
  input  wire logic [6:0]      heater_power,
  input  wire logic            heater_fail,
  input  wire logic            safety_warn,
  input  wire logic            temp_low,
  input  wire logic            temp_high,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [6:0]      cfg_data,
  output logic                 q_wr_valid,
  input  wire logic            q_wr_ready,
  output ssd_pkg::frame_t      q_wr_data
);

  typedef enum logic [1:0] {
    CLS_VALUE,
    CLS_LAMP,
    CLS_BLANK
  } cls_t;

  logic        pending;
  logic [6:0]  warm_threshold;
  logic        s1_valid;
  cls_t        s1_cls;
  logic        s1_pid;
  logic [7:0]  s1_leds;
  ssd_pkg::digit_t s1_skin_h;
  logic [6:0]  s1_skin_r;
  ssd_pkg::digit_t s1_setp_h;
  logic [6:0]  s1_setp_r;

  logic        accept;
  logic        pend_eff;
  logic        has_frame;
  logic        pending_next;
  cls_t        cls_next;
  logic [9:0]  skin_sat;
  logic [9:0]  setp_sat;
  logic [15:0] skin_hp;
  logic [15:0] setp_hp;
  ssd_pkg::digit_t skin_h;
  ssd_pkg::digit_t setp_h;
  logic [9:0]  skin_r10;
  logic [9:0]  setp_r10;
  logic [7:0]  leds_next;

  // Tens and ones of the registered remainders.
  logic [13:0] skin_tp;
  logic [13:0] setp_tp;
  ssd_pkg::digit_t skin_t;
  ssd_pkg::digit_t setp_t;
  logic [6:0]  skin_o7;
  logic [6:0]  setp_o7;
  ssd_pkg::digit_t lh, lt, lo, sh, st, so;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || q_wr_ready;
  assign accept    = in_valid && in_ready;

  // Classify the request and split off the hundreds digits.
  always_comb begin
    pend_eff     = pending | refresh_request;
    has_frame    = 1'b0;
    cls_next     = CLS_VALUE;
    pending_next = pend_eff;
    unique case (opcode)
      ssd_pkg::OP_LAMP: begin
        has_frame = 1'b1;
        cls_next  = CLS_LAMP;
      end
      ssd_pkg::OP_BLANK: begin
        has_frame = 1'b1;
        cls_next  = CLS_BLANK;
      end
      ssd_pkg::OP_SHOW: begin
        has_frame = pend_eff;
        if (pend_eff) begin
          pending_next = 1'b0;
        end
      end
      default: begin
        has_frame = 1'b0;
      end
    endcase

    skin_sat = (skin_tenths > 10'd999) ? 10'd999 : skin_tenths;
    setp_sat = (setpoint_value > 10'd999) ? 10'd999 : setpoint_value;
    // Multiplying by 41/4096 gives the exact hundreds digit below 1000.
    skin_hp  = {6'd0, skin_sat} * 16'd41;
    setp_hp  = {6'd0, setp_sat} * 16'd41;
    skin_h   = skin_hp[15:12];
    setp_h   = setp_hp[15:12];
    skin_r10 = skin_sat - ({6'd0, skin_h} * 10'd100);
    setp_r10 = setp_sat - ({6'd0, setp_h} * 10'd100);

    leds_next = {1'b0, pid_mode, (heater_power > warm_threshold), temp_low, temp_high,
                 heater_fail, safety_warn, !pid_mode};
  end

  // Control registers: refresh flag, threshold and stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= 1'b1;
      warm_threshold <= ssd_pkg::WARM_RESET;
      s1_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        warm_threshold <= cfg_data;
      end
      if (accept) begin
        pending  <= pending_next;
        s1_valid <= has_frame;
      end else if (q_wr_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls    <= cls_next;
      s1_pid    <= pid_mode;
      s1_leds   <= leds_next;
      s1_skin_h <= skin_h;
      s1_skin_r <= skin_r10[6:0];
      s1_setp_h <= setp_h;
      s1_setp_r <= setp_r10[6:0];
    end
  end

  // Finish the digit split and assemble the frame for the queue.
  always_comb begin
    // Multiplying by 103/1024 gives the exact tens digit below 100.
    skin_tp = {7'd0, s1_skin_r} * 14'd103;
    setp_tp = {7'd0, s1_setp_r} * 14'd103;
    skin_t  = skin_tp[13:10];
    setp_t  = setp_tp[13:10];
    skin_o7 = s1_skin_r - ({3'd0, skin_t} * 7'd10);
    setp_o7 = s1_setp_r - ({3'd0, setp_t} * 7'd10);

    lh = (s1_skin_h == 4'd0) ? ssd_pkg::DIGIT_DARK : s1_skin_h;
    lt = skin_t;
    lo = skin_o7[3:0];
    sh = (s1_setp_h == 4'd0) ? ssd_pkg::DIGIT_DARK : s1_setp_h;
    // In percent mode a leading zero tens digit is dark as well.
    st = (!s1_pid && s1_setp_h == 4'd0 && setp_t == 4'd0) ? ssd_pkg::DIGIT_DARK : setp_t;
    so = setp_o7[3:0];

    unique case (s1_cls)
      CLS_LAMP: begin
        q_wr_data = '1;
        q_wr_data[31:24] = 8'h7F;
      end
      CLS_BLANK: begin
        q_wr_data = '0;
      end
      default: begin
        q_wr_data = {ssd_pkg::large_seg(lo),
                     ssd_pkg::large_seg(lt) | 8'h01,
                     ssd_pkg::large_seg(lh),
                     s1_leds,
                     ssd_pkg::small_seg(so),
                     ssd_pkg::small_seg(st) | {7'd0, s1_pid},
                     ssd_pkg::small_seg(sh)};
      end
    endcase
  end

  assign q_wr_valid = s1_valid;

  // A value frame always consumes the refresh flag.
  `ASSERT_CLK(a_show_clears_pending, clk, rst, (accept && opcode == ssd_pkg::OP_SHOW && pend_eff) |=> !pending, "refresh flag still set after a value frame")

endmodule

`default_nettype wire

### sv/ssd_queue.sv
// Short frame queue between the front end and the shifter.
`default_nettype none

`include "assert_macros.svh"

module ssd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire ssd_pkg::frame_t wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output ssd_pkg::frame_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssd_pkg::frame_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // The fill count never runs past the depth.
  `ASSERT_CLK(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue fill count beyond depth")

endmodule

`default_nettype wire

### sv/ssd_back.sv
// Back end: shifts each queued frame out one bit per word, first bit first.
`default_nettype none

`include "assert_macros.svh"

module ssd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire ssd_pkg::frame_t q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 serial_bit,
  output logic                 last_bit
);

  localparam int CNT_W = $clog2(ssd_pkg::FRAME_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ssd_pkg::FRAME_BITS - 1);

  ssd_pkg::frame_t  shreg;
  logic [CNT_W-1:0] cnt;
  logic             take;
  logic             load;

  assign take       = out_valid && out_ready;
  assign load       = q_valid && (!out_valid || (take && cnt == LAST));
  assign q_ready    = load;
  assign serial_bit = shreg[ssd_pkg::FRAME_BITS-1];
  assign last_bit   = (cnt == LAST);

  // Bit counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= '0;
      end else if (take) begin
        if (cnt == LAST) begin
          out_valid <= 1'b0;
          cnt       <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= q_data;
    end else if (take) begin
      shreg <= {shreg[ssd_pkg::FRAME_BITS-2:0], 1'b0};
    end
  end

  // A new frame is loaded only when no bit of the current one is left.
  `ASSERT_NEVER(a_no_early_load, clk, rst, q_ready && out_valid && !(out_ready && last_bit), "frame loaded over unsent bits")

endmodule

`default_nettype wire

### sv/seven_segment_status_display_shifter_top.sv
// Top level of the seven-segment status display shifter.
// Requests arrive on the in channel (in_valid/in_ready) and each one that
// makes a frame yields 56 output words on the out channel, one frame bit per
// word, first bit first, with last_bit set on the 56th word so the chain's
// storage latch can strobe. A show request without a pending refresh, and
// an unused opcode, yield no words. The warm threshold is written through
// cfg_valid/cfg_data; cfg_ready is always high. A frame passes the front
// stage register and the queue before the shifter loads it, and its first
// bit is valid once the shifter has loaded it. The shifter's bit
// counter paces the output; queued frames follow one another without a
// gap. Requests keep being accepted while the queue and front stage have
// room, so up to QUEUE_DEPTH plus two frames are in flight. When the
// receiver holds out_ready low the current word is held, the queue fills
// and then in_ready falls. Reset empties the queue, drops out_valid, sets
// the refresh flag and loads a warm threshold of 80.
`default_nettype none

module seven_segment_status_display_shifter_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic       refresh_request,
  input  wire logic       pid_mode,
  input  wire logic [9:0] skin_tenths,
  input  wire logic [9:0] setpoint_value,
  input  wire logic [6:0] heater_power,
  input  wire logic       heater_fail,
  input  wire logic       safety_warn,
  input  wire logic       temp_low,
  input  wire logic       temp_high,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            serial_bit,
  output logic            last_bit,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data
);

  logic            fq_valid;
  logic            fq_ready;
  ssd_pkg::frame_t fq_data;
  logic            qb_valid;
  logic            qb_ready;
  ssd_pkg::frame_t qb_data;

  // Request handling and frame assembly.
  ssd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .refresh_request (refresh_request),
    .pid_mode        (pid_mode),
    .skin_tenths     (skin_tenths),
    .setpoint_value  (setpoint_value),
    .heater_power    (heater_power),
    .heater_fail     (heater_fail),
    .safety_warn     (safety_warn),
    .temp_low        (temp_low),
    .temp_high       (temp_high),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .q_wr_valid      (fq_valid),
    .q_wr_ready      (fq_ready),
    .q_wr_data       (fq_data)
  );

  // Frame queue.
  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Serial shifter.
  ssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .serial_bit (serial_bit),
    .last_bit   (last_bit)
  );

endmodule

`default_nettype wire

### bench/seven_segment_status_display_shifter_top_tb.sv
// Testbench for the seven-segment status display shifter: predicted frames checked bit by bit.
`default_nettype none

module seven_segment_status_display_shifter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names three opcodes; the fourth makes no frame.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SHOWN_LIMIT   = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 64;

  // Segment glyphs, indexed by digit code, dark and full included.
  localparam logic [7:0] LARGE_GLYPH [12] = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6,
                                              8'hBE, 8'hE4, 8'hFE, 8'hF6, 8'h00, 8'hFF};
  localparam logic [7:0] SMALL_GLYPH [12] = '{8'hBE, 8'h18, 8'h76, 8'h7C, 8'hD8, 8'hEC,
                                              8'hEE, 8'hB8, 8'hFE, 8'hFC, 8'h00, 8'hFF};

  typedef struct {
    logic [1:0] opcode;
    logic       refresh_request;
    logic       pid_mode;
    logic [9:0] skin_tenths;
    logic [9:0] setpoint_value;
    logic [6:0] heater_power;
    logic       heater_fail;
    logic       safety_warn;
    logic       temp_low;
    logic       temp_high;
  } display_req_t;

  typedef struct packed {
    logic serial;
    logic last;
  } frame_word_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic       refresh_request;
  logic       pid_mode;
  logic [9:0] skin_tenths;
  logic [9:0] setpoint_value;
  logic [6:0] heater_power;
  logic       heater_fail;
  logic       safety_warn;
  logic       temp_low;
  logic       temp_high;
  logic       out_valid;
  logic       out_ready;
  logic       serial_bit;
  logic       last_bit;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  // Predictor state and the frame bits still to arrive.
  logic        model_refresh_due;
  logic [6:0]  model_warm_limit;
  frame_word_t frame_bit_q[$];

  int send_idle_max = 5;
  int recv_idle_max = 5;
  int word_stall    = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int word_index    = 0;
  int cycle_count   = 0;

  seven_segment_status_display_shifter_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .refresh_request(refresh_request),
    .pid_mode       (pid_mode),
    .skin_tenths    (skin_tenths),
    .setpoint_value (setpoint_value),
    .heater_power   (heater_power),
    .heater_fail    (heater_fail),
    .safety_warn    (safety_warn),
    .temp_low       (temp_low),
    .temp_high      (temp_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .serial_bit     (serial_bit),
    .last_bit       (last_bit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up if the run hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("seven_segment_status_display_shifter_top_tb: done, errors");
    $finish;
  end

  function automatic void log_mismatch(input string detail);
    mismatch_count++;
    if (mismatch_count <= SHOWN_LIMIT) begin
      $display("%0t ns: %s", $time, detail);
    end
  endfunction

  // Packs seven display bytes into a frame, first byte sent at the top.
  function automatic ssd_pkg::frame_t assemble_frame(input ssd_pkg::digit_t l_ones,
                                                     input ssd_pkg::digit_t l_tens,
                                                     input ssd_pkg::digit_t l_hund,
                                                     input logic dot_l,
                                                     input logic [7:0] leds,
                                                     input ssd_pkg::digit_t s_ones,
                                                     input ssd_pkg::digit_t s_tens,
                                                     input ssd_pkg::digit_t s_hund,
                                                     input logic dot_s);
    return {LARGE_GLYPH[l_ones], LARGE_GLYPH[l_tens] | {7'd0, dot_l}, LARGE_GLYPH[l_hund],
            leds, SMALL_GLYPH[s_ones], SMALL_GLYPH[s_tens] | {7'd0, dot_s},
            SMALL_GLYPH[s_hund]};
  endfunction

  // Works out the frame a request makes, if any, and queues its bits.
  function automatic void predict_display(input display_req_t r);
    ssd_pkg::frame_t frame;
    logic            emit;
    logic [9:0]      skin;
    logic [9:0]      setp;
    ssd_pkg::digit_t lh, lt, lo, sh, st, so;
    logic [7:0]      leds;
    emit = 1'b1;
    frame = '0;
    if (r.refresh_request) begin
      model_refresh_due = 1'b1;
    end
    case (r.opcode)
      ssd_pkg::OP_LAMP: begin
        frame = assemble_frame(ssd_pkg::DIGIT_FULL, ssd_pkg::DIGIT_FULL, ssd_pkg::DIGIT_FULL,
                               1'b1, 8'h7F,
                               ssd_pkg::DIGIT_FULL, ssd_pkg::DIGIT_FULL, ssd_pkg::DIGIT_FULL,
                               1'b1);
      end
      ssd_pkg::OP_BLANK: begin
        frame = assemble_frame(ssd_pkg::DIGIT_DARK, ssd_pkg::DIGIT_DARK, ssd_pkg::DIGIT_DARK,
                               1'b0, 8'h00,
                               ssd_pkg::DIGIT_DARK, ssd_pkg::DIGIT_DARK, ssd_pkg::DIGIT_DARK,
                               1'b0);
      end
      ssd_pkg::OP_SHOW: begin
        if (!model_refresh_due) begin
          emit = 1'b0;
        end else begin
          skin = (r.skin_tenths > 10'd999) ? 10'd999 : r.skin_tenths;
          setp = (r.setpoint_value > 10'd999) ? 10'd999 : r.setpoint_value;
          lh = ssd_pkg::digit_t'(skin / 10'd100);
          lt = ssd_pkg::digit_t'((skin / 10'd10) % 10'd10);
          lo = ssd_pkg::digit_t'(skin % 10'd10);
          sh = ssd_pkg::digit_t'(setp / 10'd100);
          st = ssd_pkg::digit_t'((setp / 10'd10) % 10'd10);
          so = ssd_pkg::digit_t'(setp % 10'd10);
          // Leading zeros go dark; manual mode also darkens a leading zero tens digit.
          if (lh == 4'd0) begin
            lh = ssd_pkg::DIGIT_DARK;
          end
          if (sh == 4'd0) begin
            sh = ssd_pkg::DIGIT_DARK;
          end
          if (!r.pid_mode && sh == ssd_pkg::DIGIT_DARK && st == 4'd0) begin
            st = ssd_pkg::DIGIT_DARK;
          end
          leds = {1'b0, r.pid_mode, r.heater_power > model_warm_limit, r.temp_low,
                  r.temp_high, r.heater_fail, r.safety_warn, ~r.pid_mode};
          frame = assemble_frame(lo, lt, lh, 1'b1, leds, so, st, sh, r.pid_mode);
          model_refresh_due = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      for (int k = ssd_pkg::FRAME_BITS - 1; k >= 0; k--) begin
        frame_bit_q.push_back({frame[k], k == 0});
      end
    end
  endfunction

  function automatic display_req_t make_request(input logic [1:0] op, input logic refresh,
                                                input logic pid, input int skin,
                                                input int setp, input int power,
                                                input logic [3:0] flags);
    display_req_t r;
    r.opcode          = op;
    r.refresh_request = refresh;
    r.pid_mode        = pid;
    r.skin_tenths     = 10'(skin);
    r.setpoint_value  = 10'(setp);
    r.heater_power    = 7'(power);
    {r.heater_fail, r.safety_warn, r.temp_low, r.temp_high} = flags;
    return r;
  endfunction

  // Draws a display value, leaning toward small values and the saturation edge.
  function automatic logic [9:0] draw_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return 10'($urandom_range(0, 120));
    end else if (pick < 40) begin
      return 10'($urandom_range(990, 1023));
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic display_req_t random_request();
    int pick;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      op = ssd_pkg::OP_SHOW;
    end else if (pick < 72) begin
      op = ssd_pkg::OP_LAMP;
    end else if (pick < 90) begin
      op = ssd_pkg::OP_BLANK;
    end else begin
      op = OP_UNUSED;
    end
    return make_request(op, $urandom_range(0, 99) < 65, 1'($urandom_range(0, 1)),
                        int'(draw_value()), int'(draw_value()), $urandom_range(0, 127),
                        4'($urandom_range(0, 15)));
  endfunction

  // Offers one request after a random gap and holds it until accepted.
  task automatic send_request(input display_req_t r);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    opcode          <= r.opcode;
    refresh_request <= r.refresh_request;
    pid_mode        <= r.pid_mode;
    skin_tenths     <= r.skin_tenths;
    setpoint_value  <= r.setpoint_value;
    heater_power    <= r.heater_power;
    heater_fail     <= r.heater_fail;
    safety_warn     <= r.safety_warn;
    temp_low        <= r.temp_low;
    temp_high       <= r.temp_high;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_display(r);
  endtask

  // Stops offering, waits for every frame bit, then lets the front end go quiet.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_bit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_warm_limit(input logic [6:0] limit);
    settle_block();
    @(negedge clk);
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_warm_limit = limit;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: a random stall after each word, and long holds on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (word_stall > 0) begin
        out_ready <= 1'b0;
        word_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each accepted word is compared with the oldest expected frame bit.
  initial begin
    frame_word_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (frame_bit_q.size() == 0) begin
          log_mismatch($sformatf("unexpected word: serial_bit %0b last_bit %0b",
                                 serial_bit, last_bit));
        end else begin
          want = frame_bit_q.pop_front();
          if (serial_bit !== want.serial) begin
            log_mismatch($sformatf("bit %0d of frame, serial_bit: expected %0b, got %0b",
                                   word_index, want.serial, serial_bit));
          end
          if (last_bit !== want.last) begin
            log_mismatch($sformatf("bit %0d of frame, last_bit: expected %0b, got %0b",
                                   word_index, want.last, last_bit));
          end
          word_index = want.last ? 0 : word_index + 1;
        end
        word_stall = $urandom_range(0, recv_idle_max);
      end
    end
  end

  // Pending refresh after reset, requests without a pending refresh, the
  // unused opcode, and lamp test and blank leaving the flag alone.
  task automatic test_refresh_handling();
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b1, 0, 0, 0, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b1, 345, 250, 50, 4'b1010));
    send_request(make_request(OP_UNUSED, 1'b1, 1'b0, 123, 456, 90, 4'b0101));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b0, 1023, 5, 127, 4'b1111));
    send_request(make_request(ssd_pkg::OP_LAMP, 1'b0, 1'b1, 0, 0, 0, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b0, 200, 300, 10, 4'b0011));
    send_request(make_request(ssd_pkg::OP_BLANK, 1'b1, 1'b0, 1023, 1023, 127, 4'b1111));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b0, 1000, 1000, 81, 4'b0101));
    send_request(make_request(ssd_pkg::OP_LAMP, 1'b1, 1'b0, 0, 0, 0, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b1, 999, 999, 100, 4'b1000));
  endtask

  // Blanking of leading digits on both displays in both modes.
  task automatic test_digit_blanking();
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b0, 9, 50, 20, 4'b0100));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b1, 100, 7, 30, 4'b0010));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b0, 512, 100, 64, 4'b0001));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b0, 99, 0, 0, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b1, 10, 0, 1, 4'b1001));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b1, 0, 1023, 99, 4'b0110));
  endtask

  // Warm LED just at and just above thresholds of 0 and 100.
  task automatic test_warm_threshold();
    write_warm_limit(7'd0);
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b1, 365, 370, 0, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b0, 365, 40, 1, 4'b0000));
    write_warm_limit(7'd100);
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b1, 370, 365, 100, 4'b0000));
    send_request(make_request(ssd_pkg::OP_SHOW, 1'b1, 1'b0, 370, 60, 101, 4'b0000));
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    settle_block();
    send_idle_max = 0;
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      send_request(make_request($urandom_range(0, 1) ? ssd_pkg::OP_LAMP : ssd_pkg::OP_BLANK,
                                1'b1, 1'($urandom_range(0, 1)), 0, 0, 0, 4'b0000));
      send_request(make_request(ssd_pkg::OP_SHOW, 1'b0, 1'b1, int'(draw_value()),
                                int'(draw_value()), $urandom_range(0, 127),
                                4'($urandom_range(0, 15))));
    end
  endtask

  // Random requests in phases of different thresholds and idling.
  task automatic test_random_traffic();
    int send_plan [5] = '{19, 0, 0, 19, 19};
    int recv_plan [5] = '{19, 0, 19, 0, 19};
    logic [6:0] limit_plan [5];
    limit_plan = '{7'd100, 7'd0, 7'($urandom_range(0, 100)), ssd_pkg::WARM_RESET,
                   7'($urandom_range(0, 100))};
    for (int p = 0; p < 5; p++) begin
      write_warm_limit(limit_plan[p]);
      send_idle_max = send_plan[p];
      recv_idle_max = recv_plan[p];
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    opcode          = ssd_pkg::OP_SHOW;
    refresh_request = 1'b0;
    pid_mode        = 1'b0;
    skin_tenths     = '0;
    setpoint_value  = '0;
    heater_power    = '0;
    heater_fail     = 1'b0;
    safety_warn     = 1'b0;
    temp_low        = 1'b0;
    temp_high       = 1'b0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    model_refresh_due = 1'b1;
    model_warm_limit  = ssd_pkg::WARM_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_refresh_handling();
    test_digit_blanking();
    test_warm_threshold();
    test_backpressure();
    test_random_traffic();

    settle_block();
    if (frame_bit_q.size() != 0) begin
      log_mismatch($sformatf("%0d frame bits never arrived", frame_bit_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("seven_segment_status_display_shifter_top_tb: done, clean");
    end else begin
      $display("seven_segment_status_display_shifter_top_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_front.sv
sv/ssd_queue.sv
sv/ssd_back.sv
sv/seven_segment_status_display_shifter_top.sv
bench/seven_segment_status_display_shifter_top_tb.sv
